// ===== rtl/rid_pkg.sv =====
// ----------------------------------------------------------------------------
// rid_pkg
// Shared types, opcode constants and helpers for the instruction decode block.
// ----------------------------------------------------------------------------
`default_nettype none

package rid_pkg;

    // Opcodes and function codes with special handling
    localparam logic [5:0]  OP_ADD_CMP = 6'h05;   // RSUBK / CMP / CMPU
    localparam logic [5:0]  OP_IMM     = 6'h2C;
    localparam logic [5:0]  OP_BR      = 6'h26;
    localparam logic [5:0]  OP_BRI     = 6'h2E;
    localparam logic [5:0]  OP_BCC     = 6'h27;
    localparam logic [10:0] FUNC_ZERO  = 11'h000;
    localparam logic [10:0] FUNC_CMP   = 11'h001;
    localparam logic [10:0] FUNC_CMPU  = 11'h003;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_ILLEGAL = 2'd1,
        ST_UNIMPL  = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        ALU_ADD = 3'd0,
        ALU_CMP = 3'd1,
        ALU_OR  = 3'd2,
        ALU_AND = 3'd3,
        ALU_XOR = 3'd4
    } alu_op_t;

    typedef enum logic [1:0] {
        BR_NONE    = 2'd0,
        BR_STALL   = 2'd1,
        BR_DELAYED = 2'd2
    } branch_kind_t;

    typedef struct packed {
        logic [31:0] instruction;
        logic [31:0] pc_value;
        logic [31:0] reg_a_value;
        logic [31:0] reg_b_value;
        logic        carry_flag;
    } inst_t;

    typedef struct packed {
        status_t      status;
        logic [31:0]  pc_out;
        logic [4:0]   dest_reg;
        logic         write_enable;
        logic         write_source;
        alu_op_t      alu_op;
        logic [31:0]  operand_a;
        logic [31:0]  operand_b;
        logic         carry_in;
        logic         carry_update;
        logic         compare_unsigned;
        branch_kind_t branch_kind;
    } ctrl_t;

    // IMM prefix state as seen by the decoder
    typedef struct packed {
        logic        pending;
        logic [15:0] upper;
    } imm_state_t;

    // Update request from the decoder to the IMM prefix state
    typedef struct packed {
        logic        load;
        logic        clear;
        logic [15:0] upper;
    } imm_upd_t;

    // Opcodes of the full set that this subset leaves unimplemented
    function automatic logic is_unimpl(input logic [5:0] op);
        logic hit;
        begin
            case (op)
                6'h10, 6'h18, 6'h11, 6'h19, 6'h24,
                6'h30, 6'h38, 6'h31, 6'h39, 6'h32, 6'h3A,
                6'h34, 6'h3C, 6'h35, 6'h3D, 6'h36, 6'h3E,
                6'h2F, 6'h2D: hit = 1'b1;
                default:      hit = 1'b0;
            endcase
            return hit;
        end
    endfunction

endpackage

`default_nettype wire

// ===== rtl/rid_decode.sv =====
// ----------------------------------------------------------------------------
// rid_decode
// Combinational decode of one instruction into execute controls.
// ----------------------------------------------------------------------------
`default_nettype none

module rid_decode (
    input  rid_pkg::inst_t      inst,
    input  rid_pkg::imm_state_t imm,
    output rid_pkg::ctrl_t      ctrl,
    output rid_pkg::imm_upd_t   upd
);

    logic [5:0]  op;
    logic [4:0]  rd;
    logic [15:0] imm16;
    logic [10:0] func;
    logic [31:0] imm_val;
    logic [31:0] opb;

    assign op    = inst.instruction[31:26];
    assign rd    = inst.instruction[25:21];
    assign imm16 = inst.instruction[15:0];
    assign func  = inst.instruction[10:0];

    // Prefix supplies the upper half, otherwise sign-extend
    assign imm_val = imm.pending ? {imm.upper, imm16} : {{16{imm16[15]}}, imm16};
    assign opb     = op[3] ? imm_val : inst.reg_b_value;

    always_comb
    begin
        ctrl                  = '0;
        ctrl.status           = rid_pkg::ST_OK;
        ctrl.alu_op           = rid_pkg::ALU_ADD;
        ctrl.branch_kind      = rid_pkg::BR_NONE;
        ctrl.pc_out           = inst.pc_value;
        upd.load              = 1'b0;
        upd.clear             = 1'b0;
        upd.upper             = imm16;

        if (op[5:4] == 2'b00)
        begin
            // add / subtract / compare group
            if (op == rid_pkg::OP_ADD_CMP)
            begin
                if (func != rid_pkg::FUNC_ZERO && func != rid_pkg::FUNC_CMP &&
                    func != rid_pkg::FUNC_CMPU)
                begin
                    ctrl.status = rid_pkg::ST_ILLEGAL;
                end
            end
            else if (!op[3] && func != rid_pkg::FUNC_ZERO)
            begin
                ctrl.status = rid_pkg::ST_ILLEGAL;
            end

            if (ctrl.status == rid_pkg::ST_OK)
            begin
                ctrl.dest_reg     = rd;
                ctrl.write_enable = 1'b1;
                ctrl.operand_a    = inst.reg_a_value;
                ctrl.operand_b    = op[0] ? ~opb : opb;
                ctrl.carry_in     = op[1] ? inst.carry_flag : op[0];
                ctrl.carry_update = ~op[2];
                if (op == rid_pkg::OP_ADD_CMP && func != rid_pkg::FUNC_ZERO)
                begin
                    ctrl.alu_op           = rid_pkg::ALU_CMP;
                    ctrl.compare_unsigned = (func == rid_pkg::FUNC_CMPU);
                end
                upd.clear = 1'b1;
            end
        end
        else if (op[5:4] == 2'b10 && !op[2])
        begin
            // logic group: register forms need function zero
            if (!op[3] && func != rid_pkg::FUNC_ZERO)
            begin
                ctrl.status = rid_pkg::ST_ILLEGAL;
            end
            else
            begin
                ctrl.dest_reg     = rd;
                ctrl.write_enable = 1'b1;
                ctrl.operand_a    = inst.reg_a_value;
                ctrl.operand_b    = (op[1:0] == 2'b11) ? ~opb : opb;
                case (op[1:0])
                    2'b00:   ctrl.alu_op = rid_pkg::ALU_OR;
                    2'b10:   ctrl.alu_op = rid_pkg::ALU_XOR;
                    default: ctrl.alu_op = rid_pkg::ALU_AND;
                endcase
                upd.clear = 1'b1;
            end
        end
        else if (op == rid_pkg::OP_IMM)
        begin
            upd.load = 1'b1;
        end
        else if (op == rid_pkg::OP_BR || op == rid_pkg::OP_BRI)
        begin
            if (op == rid_pkg::OP_BR && func != rid_pkg::FUNC_ZERO)
            begin
                ctrl.status = rid_pkg::ST_ILLEGAL;
            end
            else
            begin
                if (inst.instruction[18])
                begin
                    ctrl.dest_reg     = rd;
                    ctrl.write_enable = 1'b1;
                    ctrl.write_source = 1'b1;
                end
                ctrl.branch_kind = inst.instruction[20] ? rid_pkg::BR_DELAYED
                                                        : rid_pkg::BR_STALL;
                ctrl.operand_a   = inst.instruction[19] ? '0 : inst.pc_value;
                ctrl.operand_b   = opb;
                upd.clear        = 1'b1;
            end
        end
        else if (op == rid_pkg::OP_BCC)
        begin
            ctrl.status = (func != rid_pkg::FUNC_ZERO) ? rid_pkg::ST_ILLEGAL
                                                       : rid_pkg::ST_UNIMPL;
        end
        else if (rid_pkg::is_unimpl(op))
        begin
            ctrl.status = rid_pkg::ST_UNIMPL;
        end
        else
        begin
            ctrl.status = rid_pkg::ST_ILLEGAL;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/rid_imm_state.sv =====
// ----------------------------------------------------------------------------
// rid_imm_state
// IMM prefix flag and latched upper immediate.
// ----------------------------------------------------------------------------
`default_nettype none

module rid_imm_state (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                advance,
    input  rid_pkg::imm_upd_t   upd,
    output rid_pkg::imm_state_t imm
);

    logic        pending_reg;
    logic        pending_next;
    logic [15:0] upper_reg;
    logic [15:0] upper_next;

    always_comb
    begin
        pending_next = pending_reg;
        upper_next   = upper_reg;
        if (advance && upd.load)
        begin
            pending_next = 1'b1;
            upper_next   = upd.upper;
        end
        else if (advance && upd.clear)
        begin
            pending_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= 1'b0;
            upper_reg   <= '0;
        end
        else
        begin
            pending_reg <= pending_next;
            upper_reg   <= upper_next;
        end
    end

    assign imm.pending = pending_reg;
    assign imm.upper   = upper_reg;

endmodule

`default_nettype wire

// ===== rtl/risc_instruction_decode_subset.sv =====
// ----------------------------------------------------------------------------
// risc_instruction_decode_subset
// Decode stage for a subset of a 32-bit soft-processor instruction set.
// ----------------------------------------------------------------------------
// Takes one instruction request per clock on the inst channel and returns one
// ctrl result per request, in order. A request passes through an input
// register, then through decode logic into the result register; throughput is
// one request per cycle with no bubbles, and both registers stall in place
// when ctrl_ready is low. The IMM prefix state is
// updated on the same edge that loads the decoded result, so an IMM followed
// directly by its consumer sees the new upper immediate without a stall.
// Illegal and unimplemented encodings return a no-op result with the status
// set and leave the prefix state untouched.
`default_nettype none

module risc_instruction_decode_subset (
    input  logic            clk,
    input  logic            rst_n,
    // instruction requests
    input  logic            inst_valid,
    output logic            inst_ready,
    input  rid_pkg::inst_t  inst,
    // decoded execute controls
    output logic            ctrl_valid,
    input  logic            ctrl_ready,
    output rid_pkg::ctrl_t  ctrl
);

    // input register
    logic                s1_valid_reg;
    logic                s1_valid_next;
    rid_pkg::inst_t      s1_data_reg;

    // result register
    logic                out_valid_reg;
    logic                out_valid_next;
    rid_pkg::ctrl_t      out_data_reg;

    logic                out_load;
    logic                s1_free;
    rid_pkg::ctrl_t      dec_ctrl;
    rid_pkg::imm_upd_t   dec_upd;
    rid_pkg::imm_state_t imm;

    // Advance the held request when the result register is empty or draining
    assign out_load   = s1_valid_reg && (!out_valid_reg || ctrl_ready);
    assign s1_free    = !s1_valid_reg || out_load;
    assign inst_ready = s1_free;

    always_comb
    begin
        s1_valid_next  = s1_free ? inst_valid : s1_valid_reg;
        out_valid_next = out_load ? 1'b1 : (ctrl_ready ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers: load on advance, hold otherwise
    always_ff @(posedge clk)
    begin
        if (s1_free && inst_valid)
        begin
            s1_data_reg <= inst;
        end
        if (out_load)
        begin
            out_data_reg <= dec_ctrl;
        end
    end

    rid_decode u_decode (
        .inst (s1_data_reg),
        .imm  (imm),
        .ctrl (dec_ctrl),
        .upd  (dec_upd)
    );

    // Commit prefix state only when the decoded request moves on
    rid_imm_state u_imm_state (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (out_load),
        .upd     (dec_upd),
        .imm     (imm)
    );

    assign ctrl_valid = out_valid_reg;
    assign ctrl       = out_data_reg;

endmodule

`default_nettype wire

// ===== rtl/rid_checker.sv =====
// ----------------------------------------------------------------------------
// rid_checker
// Port-level checks for the instruction decode block, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module rid_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           inst_valid,
    input logic           inst_ready,
    input rid_pkg::inst_t inst,
    input logic           ctrl_valid,
    input logic           ctrl_ready,
    input rid_pkg::ctrl_t ctrl
);

    // A waiting instruction request holds until taken
    assert property (@(posedge clk) disable iff (!rst_n)
        inst_valid && !inst_ready |=> inst_valid && $stable(inst))
    else $error("waiting request changed");

    // A stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        ctrl_valid && !ctrl_ready |=> ctrl_valid && $stable(ctrl))
    else $error("stalled result changed");

    // Linking to PC only happens on a branch that writes
    assert property (@(posedge clk) disable iff (!rst_n)
        ctrl_valid && ctrl.write_source |->
            ctrl.write_enable && ctrl.branch_kind != rid_pkg::BR_NONE)
    else $error("PC writeback outside a linking branch");

    // Unsigned flag only qualifies a compare
    assert property (@(posedge clk) disable iff (!rst_n)
        ctrl_valid && ctrl.compare_unsigned |-> ctrl.alu_op == rid_pkg::ALU_CMP)
    else $error("unsigned flag without compare");

    // Rejected requests carry no side effects
    assert property (@(posedge clk) disable iff (!rst_n)
        ctrl_valid && ctrl.status != rid_pkg::ST_OK |->
            !ctrl.write_enable && !ctrl.carry_update &&
            ctrl.branch_kind == rid_pkg::BR_NONE)
    else $error("rejected request has side effects");

endmodule

bind risc_instruction_decode_subset rid_checker u_rid_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .inst_valid (inst_valid),
    .inst_ready (inst_ready),
    .inst       (inst),
    .ctrl_valid (ctrl_valid),
    .ctrl_ready (ctrl_ready),
    .ctrl       (ctrl)
);

`default_nettype wire
